[rtl/mpu_pkg.sv]
// Shared constants for the modular power unit.
// Used by the channel interfaces, the modular multiplier and the top level.
// No dependencies.
package mpu_pkg;

	// Default operand width for base, exponent, modulus and result.
	localparam int OPERAND_BITS_DEFAULT = 31;

	// Modulus loaded at reset (the prime 1e9 + 7).
	localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

	// Configuration port geometry: one 32-bit register at byte address 0.
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	// Register index, taken from paddr[2].
	localparam logic REG_MODULUS = 1'b0;

endpackage

[rtl/mpu_in_if.sv]
// Operand channel of the modular power unit: base and exponent.
// Depends on mpu_pkg for the default operand width.
interface mpu_in_if
	import mpu_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
);
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] base_value;
	logic [OPERAND_BITS-1:0] exponent;

	modport source (output valid, output base_value, output exponent, input ready);
	modport sink (input valid, input base_value, input exponent, output ready);
endinterface

[rtl/mpu_out_if.sv]
// Result channel of the modular power unit: base to the exponent, mod modulus.
// Depends on mpu_pkg for the default operand width.
interface mpu_out_if
	import mpu_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
);
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

[rtl/mpu_modmul.sv]
// Bit-serial modular multiplier: result = (a * b) mod m, one bit of b per cycle.
// Depends on mpu_pkg for the default operand width. Requires a < m and m >= 2.
module mpu_modmul
	import mpu_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OPERAND_BITS-1:0] a,
	input  logic [OPERAND_BITS-1:0] b,
	input  logic [OPERAND_BITS-1:0] m,
	output logic                    busy,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] result
);
	localparam int W  = OPERAND_BITS;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W+1:0]  t;
	logic [W+1:0]  m1;
	logic [W+1:0]  m2;
	logic [W-1:0]  r_next;

	// One interleaved step: r = 2r + a*bit, then bring back below m.
	// Since r < m and a < m, the sum is below 3m, so at most 2m is taken off.
	always_comb begin
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		t  = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
		if (t >= m2) begin
			r_next = W'(t - m2);
		end else if (t >= m1) begin
			r_next = W'(t - m1);
		end else begin
			r_next = W'(t);
		end
	end

	// Control: a fixed count of W steps, MSB of b first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[W-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = r_q;

`ifndef NO_ASSERTIONS
	// A new product is never started on top of one in progress.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("modmul started while busy");

	// A finished product is a proper residue.
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < m))
		else $error("modmul result not below modulus");
`endif

endmodule

[rtl/modular_power_unit.sv]
// Modular exponentiation: each operand transaction (base_value, exponent) yields one
// result transaction power_result = base_value ^ exponent mod modulus. Work is bit-serial:
// every modular product runs on a shift-and-add multiplier. The base is first reduced,
// then each exponent bit up to its highest set bit is taken in turn, with the accumulator
// product and the squaring running side by side in two multipliers. The next operand
// transaction can be taken in the cycle after the result is loaded. One item is worked on
// at a time; a finished result waits in the output register while the next operand
// transaction is taken. A modulus of 0 or 1 gives 0 for every item.
// The modulus register sits at APB byte address 0 and resets to 1000000007.
module modular_power_unit
	import mpu_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	mpu_in_if.sink                   operands,
	mpu_out_if.source                results,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);
	localparam int W = OPERAND_BITS;
	localparam logic [W-1:0] MOD_RESET = W'(MODULUS_RESET);
	localparam logic [W-1:0] ONE       = W'(1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REDUCE = 4'b0010,
		ST_LOOP   = 4'b0100,
		ST_MULT   = 4'b1000
	} state_t;

	state_t       state_q;
	logic [W-1:0] mod_q;
	logic [W-1:0] exp_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] sq_q;
	logic         out_valid_q;
	logic [W-1:0] out_data_q;

	logic         accept;
	logic         mod_small;
	logic         out_free;
	logic         out_load;
	logic         loop_start;
	logic         mm0_start;
	logic [W-1:0] mm0_a;
	logic [W-1:0] mm0_b;
	logic         mm0_busy;
	logic         mm0_done;
	logic [W-1:0] mm0_result;
	logic         mm1_busy;
	logic         mm1_done;
	logic [W-1:0] mm1_result;
	logic         cfg_write;

	// Configuration port: zero-wait APB, register index in paddr[2].
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MODULUS);
	assign prdata    = (paddr[2] == REG_MODULUS) ? APB_DATA_BITS'(mod_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (cfg_write) begin
			mod_q <= pwdata[W-1:0];
		end
	end

	// Handshake decode.
	assign mod_small  = (mod_q[W-1:1] == '0);
	assign accept     = operands.valid && (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || results.ready;
	assign out_load   = (state_q == ST_LOOP) && (exp_q == '0) && out_free;
	assign loop_start = (state_q == ST_LOOP) && (exp_q != '0);

	// Multiplier 0 reduces the base (1 * base) on accept, then forms acc * sq.
	assign mm0_start = (accept && !mod_small) || loop_start;
	assign mm0_a     = (state_q == ST_IDLE) ? ONE : acc_q;
	assign mm0_b     = (state_q == ST_IDLE) ? operands.base_value : sq_q;

	mpu_modmul #(.OPERAND_BITS(W)) u_mul_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm0_start),
		.a      (mm0_a),
		.b      (mm0_b),
		.m      (mod_q),
		.busy   (mm0_busy),
		.done   (mm0_done),
		.result (mm0_result)
	);

	// Multiplier 1 squares the running power of the base.
	mpu_modmul #(.OPERAND_BITS(W)) u_mul_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (loop_start),
		.a      (sq_q),
		.b      (sq_q),
		.m      (mod_q),
		.busy   (mm1_busy),
		.done   (mm1_done),
		.result (mm1_result)
	);

	// Sequencer: reduce the base, then walk the exponent LSB first until it runs out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= mod_small ? ST_LOOP : ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (mm0_done) begin
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end else if (loop_start) begin
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					if (mm1_done) begin
						state_q <= ST_LOOP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: exponent shifter, accumulator and square.
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= mod_small ? '0 : operands.exponent;
			acc_q <= mod_small ? '0 : ONE;
		end else if ((state_q == ST_REDUCE) && mm0_done) begin
			sq_q <= mm0_result;
		end else if ((state_q == ST_MULT) && mm1_done) begin
			if (exp_q[0]) begin
				acc_q <= mm0_result;
			end
			sq_q  <= mm1_result;
			exp_q <= {1'b0, exp_q[W-1:1]};
		end
	end

	// Output register: holds a result transaction until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= acc_q;
		end
	end

	assign operands.ready       = (state_q == ST_IDLE);
	assign results.valid        = out_valid_q;
	assign results.power_result = out_data_q;

`ifndef NO_ASSERTIONS
	// The two multipliers are started together, so the squarer never finishes alone.
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mm1_done |-> mm0_done)
		else $error("square finished without the accumulator product");

	// Neither multiplier is left running once the sequencer is back at idle.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!mm0_busy && !mm1_busy))
		else $error("multiplier busy while idle");

	// Accumulator and square stay proper residues between steps.
	a_loop_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOOP) && !mod_small) |-> ((acc_q < mod_q) && (sq_q < mod_q)))
		else $error("operand not reduced in exponent loop");

	// Every delivered result lies below the modulus.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (mod_small || (out_data_q < mod_q)))
		else $error("result not below modulus");
`endif

endmodule

[dv/modular_power_unit_tb.sv]
// Self-checking testbench for the modular power unit: operand and result channels
// under random idling, plus modulus register writes and read-back over the APB port.
// Depends on mpu_pkg, mpu_in_if, mpu_out_if and modular_power_unit from the rtl folder.
module modular_power_unit_tb
	import mpu_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OPERAND_BITS = OPERAND_BITS_DEFAULT;
	localparam int STALL_LIMIT = 10000;
	localparam int SETTLE_CYCLES = 1100;
	localparam int PRINT_LIMIT = 20;
	localparam logic [APB_ADDR_BITS-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};
	localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR = {~REG_MODULUS, 2'b00};
	localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = '1;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	mpu_in_if #(.OPERAND_BITS(OPERAND_BITS)) op_ch ();
	mpu_out_if #(.OPERAND_BITS(OPERAND_BITS)) res_ch ();

	modular_power_unit #(.OPERAND_BITS(OPERAND_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.operands(op_ch),
		.results(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow of the modulus register and the queue of predicted powers.
	logic [OPERAND_BITS-1:0] modulus_cfg = MODULUS_RESET[OPERAND_BITS-1:0];
	logic [OPERAND_BITS-1:0] pending_powers[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int modulus_settings = 0;
	int quiet_cycles = 0;
	logic [OPERAND_BITS-1:0] wanted_power;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Square-and-multiply over every exponent bit, LSB first.
	function automatic logic [OPERAND_BITS-1:0] expected_power(
		input logic [OPERAND_BITS-1:0] base_in,
		input logic [OPERAND_BITS-1:0] exp_in,
		input logic [OPERAND_BITS-1:0] modulus_in
	);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] m;
		if (modulus_in == '0) begin
			return '0;
		end
		m = 64'(modulus_in);
		acc = 64'd1 % m;
		sq = 64'(base_in) % m;
		for (int i = 0; i < OPERAND_BITS; i++) begin
			if (exp_in[i]) begin
				acc = (acc * sq) % m;
			end
			sq = (sq * sq) % m;
		end
		return acc[OPERAND_BITS-1:0];
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_LIMIT) begin
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	// Offer one operand transaction, with optional idle cycles ahead of it.
	task automatic send_operands(input logic [OPERAND_BITS-1:0] base_in,
			input logic [OPERAND_BITS-1:0] exp_in);
		if (send_idle_pct != 0 && $urandom_range(19) == 0) begin
			op_ch.valid <= 1'b0;
			repeat ($urandom_range(400, 1)) @(posedge clk);
		end
		while ($urandom_range(99) < send_idle_pct) begin
			op_ch.valid <= 1'b0;
			@(posedge clk);
		end
		op_ch.valid <= 1'b1;
		op_ch.base_value <= base_in;
		op_ch.exponent <= exp_in;
		do @(posedge clk); while (op_ch.ready !== 1'b1);
		pending_powers.push_back(expected_power(base_in, exp_in, modulus_cfg));
		items_sent++;
	endtask

	// Hold the sender off until every predicted power has been returned.
	task automatic wait_drained();
		op_ch.valid <= 1'b0;
		while (pending_powers.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
			input logic [APB_DATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[APB_ADDR_BITS-1] == REG_MODULUS) begin
			modulus_cfg = data[OPERAND_BITS-1:0];
			modulus_settings++;
		end
		@(posedge clk);
	endtask

	// Read the modulus register back and compare it with the shadow copy.
	task automatic check_modulus_readback();
		logic [APB_DATA_BITS-1:0] data;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= MODULUS_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (data[OPERAND_BITS-1:0] !== modulus_cfg) begin
			report_mismatch("modulus read-back", data[OPERAND_BITS-1:0], modulus_cfg);
		end
		@(posedge clk);
	endtask

	task automatic set_modulus(input logic [OPERAND_BITS-1:0] value);
		wait_drained();
		apb_write(MODULUS_ADDR, APB_DATA_BITS'(value));
		check_modulus_readback();
	endtask

	// Reset modulus: field extremes, zero exponent, exponent of one, unreduced bases.
	task automatic test_reset_modulus();
		check_modulus_readback();
		send_operands('0, '0);
		send_operands(OPERAND_MAX, OPERAND_MAX);
		send_operands(OPERAND_MAX, '0);
		send_operands('0, OPERAND_MAX);
		send_operands(31'd1, OPERAND_MAX);
		send_operands(31'd2, 31'd30);
		send_operands(31'd123456789, 31'd1);
		send_operands(31'd1000000007, 31'd5);
		send_operands(31'd1000000008, 31'd7);
		send_operands(OPERAND_MAX, 31'd1);
		send_operands(31'd1000000006, 31'd3);
		send_operands(31'd12345, 31'd1000000006);
		send_operands(31'd3, 31'd1 << 30);
	endtask

	// Smallest and largest legal moduli, then the degenerate moduli of one and zero.
	task automatic test_modulus_extremes();
		set_modulus(31'd2);
		send_operands(OPERAND_MAX, 31'h2AAAAAAA);
		send_operands(31'd4, 31'd0);
		set_modulus(OPERAND_MAX);
		send_operands(OPERAND_MAX - 31'd1, OPERAND_MAX);
		send_operands(OPERAND_MAX, 31'd9);
		set_modulus(31'd1);
		send_operands(31'd5, 31'd0);
		send_operands(OPERAND_MAX, 31'h55555555);
		set_modulus(31'd0);
		send_operands(31'd7, 31'd0);
		send_operands(OPERAND_MAX, OPERAND_MAX);
		set_modulus(MODULUS_RESET[OPERAND_BITS-1:0]);
	endtask

	// A write to the unused register slot must leave the modulus alone.
	task automatic test_ignored_register();
		wait_drained();
		apb_write(SPARE_ADDR, 32'd5);
		check_modulus_readback();
		send_operands(31'd10, 31'd3);
		send_operands(31'd999999999, 31'd2);
	endtask

	// Random traffic in four modulus settings under one idling mix.
	task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_items);
		logic [OPERAND_BITS-1:0] b;
		logic [OPERAND_BITS-1:0] e;
		logic [OPERAND_BITS-1:0] m;
		logic [31:0] word;
		int pick;
		int len;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int chunk = 0; chunk < 4; chunk++) begin
			case (chunk)
				0: begin
					m = OPERAND_BITS'($urandom_range(32'h7FFFFFFF, 2));
				end
				1: begin
					m = OPERAND_BITS'($urandom_range(1024, 2));
				end
				2: begin
					m = OPERAND_MAX - OPERAND_BITS'($urandom_range(1000, 0));
				end
				default: begin
					m = ($urandom_range(1) == 0) ? MODULUS_RESET[OPERAND_BITS-1:0]
						: OPERAND_BITS'($urandom_range(65535, 2));
				end
			endcase
			set_modulus(m);
			for (int i = 0; i < n_items / 4; i++) begin
				// Base: mostly full width, some tiny, some right around the modulus.
				pick = $urandom_range(99);
				word = $urandom;
				if (pick < 70) begin
					b = word[OPERAND_BITS-1:0];
				end else if (pick < 85) begin
					b = OPERAND_BITS'($urandom_range(16));
				end else begin
					word = {1'b0, m} + $urandom_range(4) - 2;
					b = word[OPERAND_BITS-1:0];
				end
				// Exponent: mostly short to keep items fast, some full width and edges.
				pick = $urandom_range(99);
				word = $urandom;
				if (pick < 10) begin
					e = word[OPERAND_BITS-1:0];
				end else if (pick < 20) begin
					case ($urandom_range(3))
						0: e = '0;
						1: e = 31'd1;
						2: e = 31'd2;
						default: e = OPERAND_MAX;
					endcase
				end else begin
					len = $urandom_range(8);
					e = word[OPERAND_BITS-1:0] & ((31'd1 << len) - 31'd1);
				end
				send_operands(b, e);
			end
		end
		wait_drained();
	endtask

	task automatic test_streaming();
		run_random_phase(0, 0, 332);
	endtask

	task automatic test_sender_gaps();
		run_random_phase(85, 0, 332);
	endtask

	task automatic test_receiver_stalls();
		run_random_phase(0, 85, 332);
	endtask

	task automatic test_mixed_idling();
		run_random_phase(33, 33, 332);
	endtask

	// Receiver: random back-pressure, and each result transaction checked in order.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				if (pending_powers.size() == 0) begin
					report_mismatch("result with no pending item", res_ch.power_result, 0);
				end else begin
					wanted_power = pending_powers.pop_front();
					results_checked++;
					if (res_ch.power_result !== wanted_power) begin
						report_mismatch("power_result", res_ch.power_result, wanted_power);
					end
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if ((op_ch.valid === 1'b1 && op_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("modular_power_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence.
	initial begin
		arst_n <= 1'b0;
		op_ch.valid <= 1'b0;
		op_ch.base_value <= '0;
		op_ch.exponent <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_modulus();
		test_modulus_extremes();
		test_ignored_register();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_powers.size() != 0) begin
			report_mismatch("results never returned", pending_powers.size(), 0);
		end

		$display("Covered %0d operand transactions and %0d checked results over %0d modulus writes,",
			items_sent, results_checked, modulus_settings);
		$display("with free flow, sender gaps, receiver stalls and both; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("modular_power_unit regression: pass");
		end else begin
			$display("modular_power_unit regression: fail");
		end
		$finish;
	end

endmodule
